@@ rtl/olt_pkg.sv @@
// olt_pkg: shared constants, codes and types for the ordered list table
// used by olt_cell, olt_ctrl, ordered_list_table and olt_checker
// no dependencies
package olt_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int POS_W  = 4;
    localparam int OCC_W  = 5;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_MODIFY = 2'd2,
        OP_DELETE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // per-cell write command: shift takes the upper neighbour, load takes wr_data
    typedef struct packed {
        logic load;
        logic shift;
    } cell_cmd_t;

endpackage

@@ rtl/olt_cell.sv @@
// olt_cell: one list slot, holds an entry and its registered key match
// depends on olt_pkg
module olt_cell
    import olt_pkg::*;
(
    input  logic                     aclk,
    input  logic                     cmp_en,
    input  logic signed [DATA_W-1:0] cmp_key,
    input  cell_cmd_t                cmd,
    input  logic signed [DATA_W-1:0] wr_data,
    input  logic signed [DATA_W-1:0] nbr_entry,
    output logic signed [DATA_W-1:0] entry,
    output logic                     match
);

    logic signed [DATA_W-1:0] entry_reg;
    logic                     match_reg;

    always_ff @(posedge aclk) begin
        if (cmd.shift) begin
            entry_reg <= nbr_entry;
        end else if (cmd.load) begin
            entry_reg <= wr_data;
        end
        if (cmp_en) begin
            match_reg <= (entry_reg == cmp_key);
        end
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

@@ rtl/olt_ctrl.sv @@
// olt_ctrl: transaction sequencer, first-match encoder, cell commands and result register
// depends on olt_pkg
module olt_ctrl
    import olt_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  op_t                      s_op,
    input  logic signed [DATA_W-1:0] s_key,
    input  logic signed [DATA_W-1:0] s_repl,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output status_t                  m_status,
    output logic [POS_W-1:0]         m_position,
    output logic [OCC_W-1:0]         m_occupancy,
    output logic                     cmp_en,
    output cell_cmd_t [DEPTH-1:0]    cmd,
    output logic signed [DATA_W-1:0] wr_data,
    input  logic [DEPTH-1:0]         match
);

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    op_t                      op_reg;
    logic signed [DATA_W-1:0] key_reg;
    logic signed [DATA_W-1:0] repl_reg;
    status_t                  status_reg, status_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [OCC_W-1:0]         occ_reg;

    logic                     accept;
    logic [DEPTH-1:0]         hit;
    logic                     found;
    logic [IDX_W-1:0]         first_idx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= s_op;
            key_reg  <= s_key;
            repl_reg <= s_repl;
        end
        if (state_reg == S_EXEC) begin
            status_reg <= status_next;
            pos_reg    <= pos_next;
            occ_reg    <= OCC_W'(count_next);
        end
    end

    // only entries below the count take part in the search
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            hit[i] = match[i] && (CNT_W'(i) < count_reg);
        end
        found     = |hit;
        first_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (hit[i]) begin
                first_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        s_tready      = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);
        accept        = s_tvalid && s_tready;
        cmp_en        = accept;
        state_next    = state_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg;
        status_next   = ST_NOT_FOUND;
        pos_next      = '0;
        wr_data       = key_reg;
        for (int i = 0; i < DEPTH; i++) begin
            cmd[i] = '0;
        end

        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next    = S_IDLE;
                m_tvalid_next = 1'b1;
                case (op_reg)
                    OP_INSERT: begin
                        if (count_reg >= CNT_W'(DEPTH)) begin
                            status_next = ST_FULL;
                        end else begin
                            for (int i = 0; i < DEPTH; i++) begin
                                cmd[i].load = (CNT_W'(i) == count_reg);
                            end
                            status_next = ST_DONE;
                            pos_next    = POS_W'(count_reg);
                            count_next  = count_reg + CNT_W'(1);
                        end
                    end
                    OP_SEARCH: begin
                        if (found) begin
                            status_next = ST_DONE;
                            pos_next    = POS_W'(first_idx);
                        end
                    end
                    OP_MODIFY: begin
                        if (found) begin
                            wr_data = repl_reg;
                            for (int i = 0; i < DEPTH; i++) begin
                                cmd[i].load = (IDX_W'(i) == first_idx);
                            end
                            status_next = ST_DONE;
                            pos_next    = POS_W'(first_idx);
                        end
                    end
                    OP_DELETE: begin
                        if (count_reg == '0) begin
                            status_next = ST_EMPTY;
                        end else if (found) begin
                            // cells from the match upward take their neighbour's entry
                            for (int i = 0; i < DEPTH; i++) begin
                                cmd[i].shift = (IDX_W'(i) >= first_idx) &&
                                               (CNT_W'(i + 1) < count_reg);
                            end
                            status_next = ST_DONE;
                            pos_next    = POS_W'(first_idx);
                            count_next  = count_reg - CNT_W'(1);
                        end
                    end
                    default: begin
                        status_next = ST_NOT_FOUND;
                    end
                endcase
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid    = m_tvalid_reg;
    assign m_status    = status_reg;
    assign m_position  = pos_reg;
    assign m_occupancy = occ_reg;

endmodule

@@ rtl/ordered_list_table.sv @@
// ordered_list_table: top level, a row of list cells with a shared sequencer
// depends on olt_pkg, olt_cell, olt_ctrl
//
// An ordered list of up to DEPTH (16) signed 32-bit values, one value per cell.
// Each input transaction carries an operation in s_tuser (insert at the tail,
// search, modify the first match, delete the first match) and the key and the
// replacement in s_tdata; each gives exactly one result transaction with a
// status, the matched or inserted position and the occupancy afterwards.
// In the accept cycle of a transaction every cell compares its
// entry with the key and registers the match, in the next cycle the sequencer
// picks the lowest matching valid cell, issues load or shift commands to the
// cells (a delete moves each entry above the match down one cell) and loads
// the result register. The next transaction can be taken in the cycle after
// that, but only if the previous result leaves the output register in that
// same cycle; a result held by m_tready low holds off the input as well, and
// even with a ready receiver no input is taken while one is being executed.
// Entries carry no reset; the entry count is cleared instead, so no clearing
// pass is needed.
module ordered_list_table
    import olt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] key_value, [63:32] replacement
    input  logic [1:0]  s_tuser,   // [1:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] position, [8:4] occupancy, rest zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] repl;
    op_t                      op;
    status_t                  status;
    logic [POS_W-1:0]         position;
    logic [OCC_W-1:0]         occupancy;

    logic                     cmp_en;
    cell_cmd_t [DEPTH-1:0]    cmd;
    logic signed [DATA_W-1:0] wr_data;
    logic [DEPTH-1:0]         match;
    logic signed [DATA_W-1:0] entry [DEPTH];

    // unpack the input transaction
    assign key  = s_tdata[31:0];
    assign repl = s_tdata[63:32];
    assign op   = op_t'(s_tuser);

    olt_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_op        (op),
        .s_key       (key),
        .s_repl      (repl),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_status    (status),
        .m_position  (position),
        .m_occupancy (occupancy),
        .cmp_en      (cmp_en),
        .cmd         (cmd),
        .wr_data     (wr_data),
        .match       (match)
    );

    // the chain of cells: each one sees its upper neighbour for delete shifts,
    // the top cell never shifts and sees itself
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [DATA_W-1:0] nbr;
        if (g == DEPTH - 1) begin : g_top
            assign nbr = entry[g];
        end else begin : g_mid
            assign nbr = entry[g + 1];
        end
        olt_cell u_cell (
            .aclk      (aclk),
            .cmp_en    (cmp_en),
            .cmp_key   (key),
            .cmd       (cmd[g]),
            .wr_data   (wr_data),
            .nbr_entry (nbr),
            .entry     (entry[g]),
            .match     (match[g])
        );
    end

    // pack the result transaction
    assign m_tdata = {{(16 - OCC_W - POS_W){1'b0}}, occupancy, position};
    assign m_tuser = status;

endmodule

@@ rtl/olt_checker.sv @@
// olt_checker: port-level assertions for ordered_list_table, bound to the top level
// depends on olt_pkg and ordered_list_table
module olt_checker
    import olt_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // a stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one transaction at a time: no accept in the cycle after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted during execution");

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[8:4] <= OCC_W'(DEPTH))
        else $error("occupancy above depth");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_FULL |-> m_tdata[8:4] == OCC_W'(DEPTH) && m_tdata[3:0] == '0)
        else $error("full status with room left");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_EMPTY |-> m_tdata[8:0] == '0)
        else $error("empty status with entries");

endmodule

bind ordered_list_table olt_checker u_olt_checker (.*);

@@ tb/tb_ordered_list_table.sv @@
// tb_ordered_list_table: self-checking testbench for the ordered list table
// depends on olt_pkg and ordered_list_table; keeps a shadow list to predict each result
// directed list cases first, then backpressure and random traffic under varying idling
`timescale 1ns / 100ps

module tb_ordered_list_table;
    import olt_pkg::*;

    // no transaction on either channel for this many cycles means the block has hung
    localparam int WATCHDOG_LIMIT = 5000;
    // receiver hold-off during the backpressure test
    localparam int HOLD_CYCLES    = 80;

    typedef struct packed {
        status_t           status;
        logic [POS_W-1:0]  position;
        logic [OCC_W-1:0]  occupancy;
    } list_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;   // [31:0] key_value, [63:32] replacement
    logic [1:0]  s_tuser  = '0;   // [1:0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [3:0] position, [8:4] occupancy
    logic [1:0]  m_tuser;         // [1:0] status

    // shadow copy of the list, updated at every accepted input transaction
    logic [DATA_W-1:0] shadow_list [DEPTH];
    int                shadow_count = 0;
    list_result_t      pending_results [$];

    int err_cnt       = 0;
    int idle_cycles   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req      = 1'b0;

    ordered_list_table u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // applies one operation to the shadow list and returns the result it should give
    function automatic list_result_t apply_list_op(op_t op, logic [DATA_W-1:0] key,
                                                   logic [DATA_W-1:0] repl);
        list_result_t r;
        int hit;
        int i;
        r.status   = ST_NOT_FOUND;
        r.position = '0;
        hit = -1;
        for (i = 0; i < shadow_count; i++) begin
            if (hit < 0 && shadow_list[i] == key) hit = i;
        end
        case (op)
            OP_INSERT: begin
                if (shadow_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_list[shadow_count] = key;
                    r.position = POS_W'(shadow_count);
                    shadow_count++;
                    r.status = ST_DONE;
                end
            end
            OP_SEARCH: begin
                if (hit >= 0) begin
                    r.status   = ST_DONE;
                    r.position = POS_W'(hit);
                end
            end
            OP_MODIFY: begin
                if (hit >= 0) begin
                    shadow_list[hit] = repl;
                    r.status   = ST_DONE;
                    r.position = POS_W'(hit);
                end
            end
            default: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else if (hit >= 0) begin
                    // close the gap, keeping order
                    for (i = hit; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i + 1];
                    shadow_count--;
                    r.status   = ST_DONE;
                    r.position = POS_W'(hit);
                end
            end
        endcase
        r.occupancy = OCC_W'(shadow_count);
        return r;
    endfunction

    // predict on input transactions, compare on result transactions, watch for a hang
    always @(posedge aclk) begin : scoreboard
        list_result_t want;
        list_result_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                pending_results.push_back(apply_list_op(op_t'(s_tuser), s_tdata[31:0],
                                                        s_tdata[63:32]));
            if (m_tvalid && m_tready) begin
                got.status    = status_t'(m_tuser);
                got.position  = m_tdata[3:0];
                got.occupancy = m_tdata[8:4];
                if (pending_results.size() == 0) begin
                    $error("result transaction with no expectation waiting");
                    err_cnt++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.status != want.status) begin
                        $error("status mismatch: expected %s, actual %s",
                               want.status.name(), got.status.name());
                        err_cnt++;
                    end
                    if (got.position != want.position) begin
                        $error("position mismatch: expected %0d, actual %0d",
                               want.position, got.position);
                        err_cnt++;
                    end
                    if (got.occupancy != want.occupancy) begin
                        $error("occupancy mismatch: expected %0d, actual %0d",
                               want.occupancy, got.occupancy);
                        err_cnt++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    // receiver: random stalls, or one long hold-off on request
    always begin
        @(negedge aclk);
        if (hold_req) begin
            hold_req = 1'b0;
            m_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge aclk);
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // entered and left at a falling edge; valid stays high between back-to-back items
    task automatic send_item(input op_t op, input logic [DATA_W-1:0] key,
                             input logic [DATA_W-1:0] repl);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {repl, key};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // mostly keys already in the list, some from a tiny pool for duplicates, some anything
    function automatic logic [DATA_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (shadow_count > 0 && r < 55) return shadow_list[$urandom_range(shadow_count - 1)];
        if (r < 80) return DATA_W'($urandom_range(7)) - 32'd4;
        return $urandom;
    endfunction

    task automatic test_empty_list();
        send_item(OP_DELETE, 32'd5, 32'd0);
        send_item(OP_SEARCH, 32'd5, 32'd0);
        send_item(OP_MODIFY, 32'd5, 32'hFFFF_FFFF);
    endtask

    // duplicates, first-match rule, modify and delete with the shift down
    task automatic test_match_order();
        send_item(OP_INSERT, 32'h8000_0000, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 32'h7FFF_FFFF, 32'h0);
        send_item(OP_INSERT, 32'h7FFF_FFFF, 32'h0);
        send_item(OP_SEARCH, 32'h7FFF_FFFF, 32'h0);
        send_item(OP_MODIFY, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(OP_SEARCH, 32'h8000_0000, 32'h0);
        send_item(OP_DELETE, 32'h8000_0000, 32'h0);
        send_item(OP_DELETE, 32'h0001_2345, 32'h0);
    endtask

    task automatic test_full_list();
        send_item(OP_INSERT, 32'h0, 32'h0);
        send_item(OP_INSERT, 32'hFFFF_FFFF, 32'h0);
        while (shadow_count < DEPTH) send_item(OP_INSERT, $urandom, $urandom);
        send_item(OP_INSERT, 32'h1234_5678, 32'h0);
        send_item(OP_SEARCH, shadow_list[DEPTH-1], 32'h0);
        send_item(OP_MODIFY, shadow_list[DEPTH-1], 32'h7FFF_FFFF);
        send_item(OP_DELETE, shadow_list[0], 32'h0);
        wait_for_results();
    endtask

    // long receiver hold-off while the sender keeps offering, then a full drain
    task automatic test_backpressure();
        int k;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        for (k = 0; k < 24; k++)
            send_item(($urandom_range(1) != 0) ? OP_INSERT : OP_SEARCH, pick_key(), $urandom);
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int n_items, input int tx_idle, input int rx_idle);
        int k;
        int r;
        bit filling;
        op_t op;
        send_idle_pct = tx_idle;
        recv_idle_pct = rx_idle;
        for (k = 0; k < n_items; k++) begin
            // alternate between growing and shrinking the list so both ends get reached
            filling = ((k / 40) % 2) == 0;
            r = $urandom_range(99);
            if (filling)
                op = (r < 50) ? OP_INSERT : (r < 65) ? OP_SEARCH : (r < 80) ? OP_MODIFY
                                                                          : OP_DELETE;
            else
                op = (r < 15) ? OP_INSERT : (r < 35) ? OP_SEARCH : (r < 55) ? OP_MODIFY
                                                                          : OP_DELETE;
            send_item(op, pick_key(), ($urandom_range(3) == 0) ? pick_key() : $urandom);
        end
        wait_for_results();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_empty_list();
        test_match_order();
        test_full_list();
        test_backpressure();
        test_random_traffic(260, 32, 70);
        test_random_traffic(260, 70, 32);
        test_random_traffic(260, 0, 0);

        wait_for_results();
        repeat (10) @(negedge aclk);
        if (err_cnt == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/olt_pkg.sv
rtl/olt_cell.sv
rtl/olt_ctrl.sv
rtl/ordered_list_table.sv
rtl/olt_checker.sv
tb/tb_ordered_list_table.sv
